// ----- sv/iqmh_pkg.sv -----
package iqmh_pkg;

  localparam int HEAP_DEPTH_DEF = 64;
  localparam int ID_SPACE_DEF   = 64;
  localparam int KEY_BITS_DEF   = 16;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 6;
  localparam int PRI_W  = 16;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_UPD = 2'd2,
    CMD_REM = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_ABSENT  = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item, read present bit
    logic start;    // decide the command
    logic rd_req;   // marks the memory read for current step
    logic eval;     // evaluate one sift step
    logic finish;   // register result item
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;     // sift still in progress
  } dp_stat_t;

endpackage

// ----- sv/iqmh_ctrl.sv -----
module iqmh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_free,
  input  iqmh_pkg::dp_stat_t  stat,
  output iqmh_pkg::dp_cmd_t   cmd,
  output logic                in_ready
);
  import iqmh_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_READ  = 6'b000100,
    S_EVAL  = 6'b001000,
    S_DONE  = 6'b010000,
    S_LOAD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_START;
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        if (stat.busy) begin
          cmd.rd_req = 1'b1;
          state_nxt = S_EVAL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = S_READ;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- sv/iqmh_dp.sv -----
module iqmh_dp #(
  parameter int HEAP_DEPTH = iqmh_pkg::HEAP_DEPTH_DEF,
  parameter int ID_SPACE   = iqmh_pkg::ID_SPACE_DEF,
  parameter int KEY_BITS   = iqmh_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iqmh_pkg::dp_cmd_t             cmd,
  input  logic [iqmh_pkg::CMD_W-1:0]    in_cmd,
  input  logic [iqmh_pkg::ID_W-1:0]     in_elem_id,
  input  logic [iqmh_pkg::PRI_W-1:0]    in_priority_req,
  output iqmh_pkg::dp_stat_t            stat,
  output logic [iqmh_pkg::STAT_W-1:0]   res_status,
  output logic [iqmh_pkg::ID_W-1:0]     res_out_id,
  output logic [iqmh_pkg::PRI_W-1:0]    res_out_priority,
  output logic [iqmh_pkg::CNT_W-1:0]    res_count,
  output logic                          res_head_valid,
  output logic [iqmh_pkg::ID_W-1:0]     res_head_id,
  output logic [iqmh_pkg::PRI_W-1:0]    res_head_priority
);
  import iqmh_pkg::*;

  localparam int PW  = $clog2(HEAP_DEPTH);
  localparam int FW  = $clog2(HEAP_DEPTH + 1);
  localparam int IW  = $clog2(ID_SPACE);
  localparam int CPW = PW + 3;
  localparam int KB  = (KEY_BITS < PRI_W) ? KEY_BITS : PRI_W;

  typedef logic [KB-1:0] key_t;
  typedef logic [ID_W-1:0] sid_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LAST = 3'd1,
    PH_SIFT = 3'd2,
    PH_WAIT = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  // heap slot memory, stored as a single array of {id,key}
  // indexed by slot position; the single read port reads one slot
  logic [ID_W+KB-1:0] heap_mem [HEAP_DEPTH];
  logic [PW-1:0]      pos_mem  [ID_SPACE];
  logic [ID_SPACE-1:0] present_r;

  // captured item
  cmd_t               cmd_r;
  logic [ID_W-1:0]    id_r;
  key_t               key_r;
  logic               known_r;

  logic [FW-1:0]      fill_r;
  logic               busy_r;
  logic               up_r;       // current direction: rise
  logic               first_r;    // settle not yet decided
  logic [PW-1:0]      pos_r;
  sid_t               cur_id_r;
  key_t               cur_key_r;
  logic [2:0]         ci_r;       // child scan index 0..4, 4 = parent/decide
  logic [PW-1:0]      best_pos_r;
  key_t               best_key_r;
  sid_t               best_id_r;
  logic               best_is_r;

  logic [STAT_W-1:0]  st_r;
  sid_t               got_id_r;
  key_t               got_key_r;

  // single read port with registered data
  logic [PW-1:0]      rd_addr;
  logic [ID_W+KB-1:0] rd_data_r;
  logic [PW-1:0]      pos_rd_r;

  // memory write
  logic               hw_en;
  logic [PW-1:0]      hw_addr;
  logic [ID_W+KB-1:0] hw_data;
  logic               pw_en;
  logic [IW-1:0]      pw_addr;
  logic [PW-1:0]      pw_data;

  // phase: load reads pos; start reads slot; each rd_req reads one slot
  logic [2:0]         phase_r;    // current phase of the operation (phase_t)

  always_ff @(posedge clk) begin
    if (hw_en) heap_mem[hw_addr] <= hw_data;
    rd_data_r <= heap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pw_en) pos_mem[pw_addr] <= pw_data;
    pos_rd_r <= pos_mem[id_r[IW-1:0]];
  end

  // address arithmetic
  logic [CPW-1:0] child_base;
  logic [CPW-1:0] child_pos;
  logic [PW-1:0]  parent_pos;
  logic [FW-1:0]  last_pos;
  assign child_base = {pos_r, 2'b00} + CPW'(1);
  assign child_pos  = child_base + CPW'(ci_r[1:0]);
  assign parent_pos = PW'((pos_r - PW'(1)) >> 2);
  assign last_pos   = fill_r - FW'(1);

  logic child_ok;
  assign child_ok = (child_pos < CPW'(fill_r)) && !ci_r[2];

  always_comb begin
    if (cmd.start) begin
      rd_addr = '0;
    end else if (phase_r == PH_LAST) begin
      rd_addr = (cmd_r == CMD_REM && !best_is_r) ? pos_r : PW'(fill_r);
    end else if (up_r || first_r) begin
      rd_addr = parent_pos;
    end else begin
      rd_addr = child_pos[PW-1:0];
    end
  end

  // id and key fields of the read slot
  sid_t rd_id;
  key_t rd_key;
  assign rd_id  = rd_data_r[ID_W+KB-1:KB];
  assign rd_key = rd_data_r[KB-1:0];

  // head tracking: root kept in registers
  sid_t head_id_r;
  key_t head_key_r;

  logic here;
  assign here = known_r && present_r[id_r[IW-1:0]];

  always_comb begin
    hw_en = 1'b0; hw_addr = pos_r; hw_data = {cur_id_r, cur_key_r};
    pw_en = 1'b0; pw_addr = cur_id_r[IW-1:0]; pw_data = pos_r;
    if (cmd.eval && phase_r == PH_SIFT && ci_r[2] && !first_r) begin
      // commit a move: write the winner into pos_r
      if (up_r) begin
        if (pos_r != '0 && cur_key_r < rd_key) begin
          hw_en = 1'b1; hw_data = rd_data_r;
          pw_en = 1'b1; pw_addr = rd_id[IW-1:0];
        end else begin
          hw_en = 1'b1; pw_en = 1'b1;
        end
      end else begin
        hw_en = 1'b1;
        if (!best_is_r) begin
          hw_data = {best_id_r, best_key_r};
          pw_addr = best_id_r[IW-1:0];
        end
        pw_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      fill_r    <= '0;
      busy_r    <= 1'b0;
      phase_r   <= PH_IDLE;
    end else begin
      if (cmd.load) begin
        cmd_r   <= cmd_t'(in_cmd);
        id_r    <= in_elem_id;
        key_r   <= KB'(in_priority_req);
        known_r <= (32'(in_elem_id) < ID_SPACE);
      end
      if (cmd.start) begin
        st_r     <= ST_OK;
        got_id_r <= '0;
        got_key_r <= '0;
        busy_r   <= 1'b0;
        first_r  <= 1'b0;
        up_r     <= 1'b0;
        ci_r     <= '0;
        best_is_r <= 1'b0;
        phase_r  <= PH_IDLE;
        unique case (cmd_r)
          CMD_ENQ: begin
            if (!known_r) st_r <= ST_ABSENT;
            else if (here) st_r <= ST_PRESENT;
            else if (fill_r >= FW'(HEAP_DEPTH)) st_r <= ST_FULL;
            else begin
              present_r[id_r[IW-1:0]] <= 1'b1;
              pos_r     <= PW'(fill_r);
              cur_id_r  <= id_r;
              cur_key_r <= key_r;
              fill_r    <= fill_r + FW'(1);
              up_r      <= 1'b1;
              ci_r      <= 3'd4;
              busy_r    <= 1'b1;
              phase_r   <= PH_SIFT;
            end
          end
          CMD_DEQ: begin
            if (fill_r == '0) st_r <= ST_EMPTY;
            else begin
              got_id_r  <= head_id_r;
              got_key_r <= head_key_r;
              present_r[head_id_r[IW-1:0]] <= 1'b0;
              fill_r    <= fill_r - FW'(1);
              pos_r     <= '0;
              if (last_pos != '0) begin
                busy_r  <= 1'b1;
                phase_r <= PH_LAST;
              end
            end
          end
          default: begin
            if (!here) st_r <= ST_ABSENT;
            else if (cmd_r == CMD_UPD) begin
              pos_r     <= pos_rd_r;
              cur_id_r  <= id_r;
              cur_key_r <= key_r;
              first_r   <= 1'b1;
              ci_r      <= 3'd4;
              busy_r    <= 1'b1;
              phase_r   <= PH_SIFT;
            end else begin
              got_id_r <= id_r;
              present_r[id_r[IW-1:0]] <= 1'b0;
              fill_r   <= fill_r - FW'(1);
              pos_r    <= pos_rd_r;
              busy_r   <= 1'b1;
              phase_r  <= PH_LAST;
            end
          end
        endcase
      end
      if (cmd.eval) begin
        unique case (phase_t'(phase_r))
          PH_LAST: begin
            // rd_data is slot at last index (fill already reduced); for remove
            // the first pass reads the removed slot key first
            if (cmd_r == CMD_REM && !best_is_r) begin
              got_key_r  <= rd_key;
              best_is_r  <= 1'b1;
              if (pos_r == PW'(fill_r)) begin
                busy_r <= 1'b0;
              end
            end else begin
              cur_id_r  <= rd_id;
              cur_key_r <= rd_key;
              first_r   <= (cmd_r == CMD_REM);
              ci_r      <= (cmd_r == CMD_REM) ? 3'd4 : 3'd0;
              best_pos_r <= pos_r;
              best_is_r <= 1'b1;
              best_key_r <= rd_key;
              best_id_r <= rd_id;
              phase_r   <= PH_SIFT;
            end
          end
          PH_SIFT: begin
            if (first_r) begin
              // settle decision against parent
              first_r <= 1'b0;
              if (pos_r != '0 && cur_key_r < rd_key) begin
                up_r <= 1'b1;
                ci_r <= 3'd4;
              end else begin
                up_r <= 1'b0;
                ci_r <= 3'd0;
                best_pos_r <= pos_r; best_is_r <= 1'b1;
                best_key_r <= cur_key_r; best_id_r <= cur_id_r;
              end
            end else if (up_r) begin
              if (pos_r != '0 && cur_key_r < rd_key) begin
                pos_r <= parent_pos;
              end else begin
                busy_r <= 1'b0;
              end
            end else if (!ci_r[2]) begin
              if (child_ok && rd_key < best_key_r) begin
                best_pos_r <= child_pos[PW-1:0];
                best_key_r <= rd_key;
                best_id_r  <= rd_id;
                best_is_r  <= 1'b0;
              end
              ci_r <= ci_r + 3'd1;
            end else begin
              if (best_is_r) begin
                busy_r <= 1'b0;
              end else begin
                pos_r <= best_pos_r;
                ci_r  <= '0;
                best_pos_r <= best_pos_r;
                best_key_r <= cur_key_r;
                best_id_r  <= cur_id_r;
                best_is_r  <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        phase_r <= PH_IDLE;
      end
    end
  end

  // head shadow registers track slot zero writes
  always_ff @(posedge clk) begin
    if (hw_en && hw_addr == '0) begin
      head_id_r  <= hw_data[ID_W+KB-1:KB];
      head_key_r <= hw_data[KB-1:0];
    end else if (cmd.eval && phase_r == PH_SIFT && !up_r && !first_r && ci_r[2]
                 && best_is_r && pos_r == '0) begin
      head_id_r  <= cur_id_r;
      head_key_r <= cur_key_r;
    end
  end

  assign stat.busy = busy_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status       <= st_r;
      res_out_id       <= got_id_r;
      res_out_priority <= PRI_W'(got_key_r);
      res_count        <= CNT_W'(fill_r);
      res_head_valid   <= (fill_r != '0);
      res_head_id      <= (fill_r != '0) ? head_id_r : '0;
      res_head_priority <= (fill_r != '0) ? PRI_W'(head_key_r) : '0;
    end
  end

endmodule

// ----- sv/indexed_quaternary_min_heap.sv -----
// each sift step reads one heap slot
// a level down takes five steps, a level up one; at most 23 steps at depth 64
// one item at a time: a new item is accepted only in idle
// the sift walk over the single-port slot memory sets the item time
// reset: synchronous active low, clears presence map, fill count and control
module indexed_quaternary_min_heap #(
  parameter int HEAP_DEPTH = iqmh_pkg::HEAP_DEPTH_DEF,
  parameter int ID_SPACE   = iqmh_pkg::ID_SPACE_DEF,
  parameter int KEY_BITS   = iqmh_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cmd, elem_id, priority_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // status, out_id, out_priority, count, head_valid,
                                  // head_id, head_priority
);
  import iqmh_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_fire;
  logic     out_free;
  logic     out_valid_r;

  logic [STAT_W-1:0] r_status;
  logic [ID_W-1:0]   r_out_id;
  logic [PRI_W-1:0]  r_out_pri;
  logic [CNT_W-1:0]  r_count;
  logic              r_hv;
  logic [ID_W-1:0]   r_hid;
  logic [PRI_W-1:0]  r_hpri;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  iqmh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  iqmh_dp #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .ID_SPACE   (ID_SPACE),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_cmd            (in_tdata[1:0]),
    .in_elem_id        (in_tdata[7:2]),
    .in_priority_req   (in_tdata[23:8]),
    .stat              (stat),
    .res_status        (r_status),
    .res_out_id        (r_out_id),
    .res_out_priority  (r_out_pri),
    .res_count         (r_count),
    .res_head_valid    (r_hv),
    .res_head_id       (r_hid),
    .res_head_priority (r_hpri)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, r_hpri, r_hid, r_hv, r_count, r_out_pri, r_out_id, r_status};

endmodule
